@@ hw/rtl/mat4_pkg.sv @@
package mat4_pkg;

	localparam int DIM_DEF       = 4;
	localparam int FRAC_BITS_DEF = 16;
	localparam int VAL_W         = 32;
	// widest element index, for the largest supported matrix size of eight
	localparam int IDX_MAX_W     = 3;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_ADD = 2'd1,
		OP_SUB = 2'd2,
		OP_CMP = 2'd3
	} op_t;

	// control word travelling down the pipeline with each memory read
	typedef struct packed {
		logic                 valid;
		op_t                  op;
		logic [IDX_MAX_W-1:0] row;
		logic [IDX_MAX_W-1:0] col;
		logic                 first;
		logic                 lastk;
		logic                 fin;
	} ctl_t;

	// clamp a sum or difference of two elements to the element range
	function automatic logic [VAL_W-1:0] sat_sum(input logic [VAL_W:0] s);
		if (s[VAL_W] != s[VAL_W-1]) begin
			return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end
		return s[VAL_W-1:0];
	endfunction

endpackage

@@ hw/rtl/matrix4_multiply_add_sub_unit.sv @@
// channel  | handshake             | word
// ---------+-----------------------+--------------------------------------------
// input    | in_valid / in_stall   | a_value, b_value, row, col, opcode, last
// output   | out_valid / out_stall | value, out_row, out_col, equal, end_of_run
//
// a word without last is written to both element stores when row and col are below DIM
// a word with last is written, then in_stall stays high while the stores are read once a cycle
// unless a stalled result waits; multiply walks k per element (one shared multiply-accumulate),
// and the others read each element once; compare gives a single result at the end of the run
// out_stall with a result waiting freezes the read, multiply and accumulate stages in place
// reset clears control only; the element stores hold no reset value
module matrix4_multiply_add_sub_unit #(
	parameter int DIM       = mat4_pkg::DIM_DEF,
	parameter int FRAC_BITS = mat4_pkg::FRAC_BITS_DEF,
	parameter int IDX_W     = (DIM > 1) ? $clog2(DIM) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [mat4_pkg::VAL_W-1:0] a_value,
	input  logic signed [mat4_pkg::VAL_W-1:0] b_value,
	input  logic [IDX_W-1:0]                  row,
	input  logic [IDX_W-1:0]                  col,
	input  logic [1:0]                        opcode,
	input  logic                              last,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [mat4_pkg::VAL_W-1:0] value,
	output logic [IDX_W-1:0]                  out_row,
	output logic [IDX_W-1:0]                  out_col,
	output logic                              equal,
	output logic                              end_of_run
);
	import mat4_pkg::*;

	localparam int ADDR_W = $clog2(DIM * DIM);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [IDX_W-1:0] i_q;
	logic [IDX_W-1:0] j_q;
	logic [IDX_W-1:0] k_q;

	logic              accept;
	logic              in_range;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr_a;
	logic [ADDR_W-1:0] raddr_b;
	logic              adv;
	logic              issue;
	logic              is_mul;
	logic              is_cmp;
	logic              k_wrap;
	logic              j_wrap;
	logic              i_wrap;
	logic              final_rd;
	ctl_t              ctl_issue;
	ctl_t              ctl_s1;

	logic signed [VAL_W-1:0] a_s1;
	logic signed [VAL_W-1:0] b_s1;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_range = ({1'b0, row} < (IDX_W+1)'(DIM)) && ({1'b0, col} < (IDX_W+1)'(DIM));
	assign we       = accept && in_range;
	assign waddr    = ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);

	assign is_mul   = (op_q == OP_MUL);
	assign is_cmp   = (op_q == OP_CMP);
	assign issue    = (state_q == ST_RUN) && adv;
	assign k_wrap   = !is_mul || (k_q == LAST_IDX);
	assign j_wrap   = (j_q == LAST_IDX);
	assign i_wrap   = (i_q == LAST_IDX);
	assign final_rd = k_wrap && j_wrap && i_wrap;

	// multiply walks row i of A against column j of B, the others walk element (i, j)
	assign raddr_a = is_mul ? ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(k_q)
	                        : ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(j_q);
	assign raddr_b = is_mul ? ADDR_W'(k_q) * ADDR_W'(DIM) + ADDR_W'(j_q)
	                        : ADDR_W'(i_q) * ADDR_W'(DIM) + ADDR_W'(j_q);

	always_comb begin
		ctl_issue       = '0;
		ctl_issue.valid = issue;
		ctl_issue.op    = op_q;
		ctl_issue.row   = IDX_MAX_W'(i_q);
		ctl_issue.col   = IDX_MAX_W'(j_q);
		ctl_issue.first = is_mul ? (k_q == '0)
		                         : (!is_cmp || ((i_q == '0) && (j_q == '0)));
		ctl_issue.lastk = k_wrap && (!is_cmp || final_rd);
		ctl_issue.fin   = final_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_MUL;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			ctl_s1  <= '0;
		end else begin
			if (adv) begin
				ctl_s1 <= ctl_issue;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && last) begin
						state_q <= ST_RUN;
						op_q    <= op_t'(opcode);
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
					end
				end
				ST_RUN: begin
					if (issue) begin
						k_q <= k_wrap ? '0 : k_q + 1'b1;
						if (k_wrap) begin
							j_q <= j_wrap ? '0 : j_q + 1'b1;
							if (j_wrap) begin
								i_q <= i_wrap ? '0 : i_q + 1'b1;
							end
						end
						if (final_rd) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	mat4_store #(
		.DIM(DIM)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata_a (a_value),
		.wdata_b (b_value),
		.re      (issue),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (a_s1),
		.rdata_b (b_s1)
	);

	mat4_datapath #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS),
		.IDX_W     (IDX_W)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.a_s1       (a_s1),
		.b_s1       (b_s1),
		.out_stall  (out_stall),
		.adv        (adv),
		.out_valid  (out_valid),
		.value      (value),
		.out_row    (out_row),
		.out_col    (out_col),
		.equal      (equal),
		.end_of_run (end_of_run)
	);

endmodule

@@ hw/rtl/mat4_store.sv @@
module mat4_store #(
	parameter int DIM = mat4_pkg::DIM_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [$clog2(DIM*DIM)-1:0]            waddr,
	input  logic signed [mat4_pkg::VAL_W-1:0]     wdata_a,
	input  logic signed [mat4_pkg::VAL_W-1:0]     wdata_b,
	input  logic                                  re,
	input  logic [$clog2(DIM*DIM)-1:0]            raddr_a,
	input  logic [$clog2(DIM*DIM)-1:0]            raddr_b,
	output logic signed [mat4_pkg::VAL_W-1:0]     rdata_a,
	output logic signed [mat4_pkg::VAL_W-1:0]     rdata_b
);
	import mat4_pkg::*;

	localparam int DEPTH = DIM * DIM;

	logic [VAL_W-1:0] left_mem  [DEPTH];
	logic [VAL_W-1:0] right_mem [DEPTH];
	logic [VAL_W-1:0] rd_a_q;
	logic [VAL_W-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			left_mem[waddr]  <= wdata_a;
			right_mem[waddr] <= wdata_b;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_a_q <= left_mem[raddr_a];
			rd_b_q <= right_mem[raddr_b];
		end
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;

endmodule

@@ hw/rtl/mat4_datapath.sv @@
module mat4_datapath #(
	parameter int DIM       = mat4_pkg::DIM_DEF,
	parameter int FRAC_BITS = mat4_pkg::FRAC_BITS_DEF,
	parameter int IDX_W     = $clog2(mat4_pkg::DIM_DEF)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mat4_pkg::ctl_t                    ctl_s1,
	input  logic signed [mat4_pkg::VAL_W-1:0] a_s1,
	input  logic signed [mat4_pkg::VAL_W-1:0] b_s1,
	input  logic                              out_stall,
	output logic                              adv,
	output logic                              out_valid,
	output logic signed [mat4_pkg::VAL_W-1:0] value,
	output logic [IDX_W-1:0]                  out_row,
	output logic [IDX_W-1:0]                  out_col,
	output logic                              equal,
	output logic                              end_of_run
);
	import mat4_pkg::*;

	localparam int PROD_W = 2 * VAL_W;
	localparam int TERM_W = PROD_W - FRAC_BITS;
	localparam int ACC_W  = TERM_W + $clog2(DIM);
	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(32'sh7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(32'sh8000_0000);

	ctl_t                     ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic [VAL_W:0]           sum_s2;
	logic                     eq_s2;

	logic signed [TERM_W-1:0] term;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_sum;
	logic [VAL_W-1:0]         acc_sat;
	logic                     eq_q;
	logic                     eq_run;
	logic [VAL_W-1:0]         res_value;
	logic                     load;

	logic                     out_valid_q;
	logic [VAL_W-1:0]         value_q;
	logic [IDX_W-1:0]         row_q;
	logic [IDX_W-1:0]         col_q;
	logic                     equal_q;
	logic                     end_q;

	// whole pipeline holds while a finished word waits at the output and out_stall is high
	assign adv = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= PROD_W'(a_s1) * PROD_W'(b_s1);
			sum_s2  <= (ctl_s1.op == OP_SUB) ? ((VAL_W+1)'(a_s1) - (VAL_W+1)'(b_s1))
			                                 : ((VAL_W+1)'(a_s1) + (VAL_W+1)'(b_s1));
			eq_s2   <= (a_s1 == b_s1);
		end
	end

	// arithmetic shift of the product, rounds toward minus infinity
	assign term    = prod_s2[PROD_W-1:FRAC_BITS];
	assign acc_sum = (ctl_s2.first ? '0 : acc_q) + ACC_W'(term);
	assign eq_run  = (ctl_s2.first || eq_q) && eq_s2;

	always_comb begin
		if (acc_sum > ACC_HI) begin
			acc_sat = ACC_HI[VAL_W-1:0];
		end else if (acc_sum < ACC_LO) begin
			acc_sat = ACC_LO[VAL_W-1:0];
		end else begin
			acc_sat = acc_sum[VAL_W-1:0];
		end
	end

	always_comb begin
		unique case (ctl_s2.op)
			OP_MUL:         res_value = acc_sat;
			OP_ADD, OP_SUB: res_value = sat_sum(sum_s2);
			OP_CMP:         res_value = '0;
			default:        res_value = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.valid) begin
			acc_q <= acc_sum;
			eq_q  <= eq_run;
		end
	end

	assign load = adv && ctl_s2.valid && ctl_s2.lastk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s2.valid && ctl_s2.lastk;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= res_value;
			if (ctl_s2.op == OP_CMP) begin
				row_q   <= '0;
				col_q   <= '0;
				equal_q <= eq_run;
			end else begin
				row_q   <= ctl_s2.row[IDX_W-1:0];
				col_q   <= ctl_s2.col[IDX_W-1:0];
				equal_q <= 1'b0;
			end
			end_q <= ctl_s2.fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign out_row    = row_q;
	assign out_col    = col_q;
	assign equal      = equal_q;
	assign end_of_run = end_q;

endmodule

@@ hw/rtl/mat4_checker.sv @@
module mat4_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              last,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic signed [mat4_pkg::VAL_W-1:0] value,
	input logic                              equal,
	input logic                              end_of_run
);
	import mat4_pkg::*;

	// a word marked last starts a run, so the input must stall next
	a_run_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last |=> in_stall)
		else $error("input not stalled after last word");

	// only the single compare result may carry the equal flag
	a_equal_only_compare: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && equal |-> end_of_run && (value == '0))
		else $error("equal flag on a matrix result");

	// after a result that is not the last leaves, the input is still stalled or another result is valid
	a_no_result_while_idle_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !end_of_run |=> in_stall || out_valid)
		else $error("run ended before its final word");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(end_of_run))
		else $error("stalled output word changed");

endmodule

bind matrix4_multiply_add_sub_unit mat4_checker u_mat4_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last       (last),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.value      (value),
	.equal      (equal),
	.end_of_run (end_of_run)
);
